>>> rtl/rmth_pkg.sv
package rmth_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CAPACITY   = 1024;
  localparam int unsigned HEAP_DEPTH = CAPACITY / 2 + 2;
  localparam int unsigned ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int unsigned CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned SCNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned MIDX_W     = 10;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [CNT_W:0]           cntw_t;
  typedef logic [SCNT_W-1:0]        scnt_t;
  typedef logic [MIDX_W-1:0]        midx_t;

  localparam scnt_t CAP_FULL = scnt_t'(CAPACITY);

endpackage

>>> rtl/running_median_two_heaps_top.sv
// Running median over two heaps held in single-port-write RAMs.
// Each transaction sifts serially by read-compare-write, one heap level at a time,
// so it takes longer as the heaps grow deeper. Reset empties both heaps at once.
// Throughput: one transaction at a time; busy stays high until it ends. An accepted
// sample gives a result only at an odd count; an overflow answers in the next cycle.
// The receiver cannot stall: each result shows for one cycle on strobe_o.
module running_median_two_heaps_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [31:0]          sample_i,
  input  logic                        first_i,
  output logic                        strobe_o,
  output logic signed [31:0]          median_o,
  output logic                        overflow_o,
  output logic [9:0]                  median_index_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_UP    = 4'd1;
  localparam logic [3:0] S_UPC   = 4'd2;
  localparam logic [3:0] S_AFTER = 4'd3;
  localparam logic [3:0] S_DNL   = 4'd4;
  localparam logic [3:0] S_DN    = 4'd5;
  localparam logic [3:0] S_DNLT  = 4'd6;
  localparam logic [3:0] S_DNR   = 4'd7;
  localparam logic [3:0] S_PUSH2 = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0]      state_q, state_d;
  logic            sel_q, sel_d;
  logic            phase_q, phase_d;
  rmth_pkg::data_t key_q, key_d, popped_q, popped_d, best_val_q, best_val_d;
  logic            best_left_q, best_left_d;
  rmth_pkg::cnt_t  idx_q, idx_d, n_q, n_d;
  rmth_pkg::cnt_t  lcnt_q, lcnt_d, ucnt_q, ucnt_d;
  rmth_pkg::scnt_t scnt_q, scnt_d;
  rmth_pkg::midx_t mcnt_q, mcnt_d;
  rmth_pkg::data_t ltop_q, ltop_d, utop_q, utop_d;
  logic            strobe_q, strobe_d, ovf_q, ovf_d;
  rmth_pkg::data_t med_q, med_d;
  rmth_pkg::midx_t midx_q, midx_d;

  logic            mem_we;
  rmth_pkg::addr_t mem_waddr, mem_raddr;
  rmth_pkg::data_t mem_wdata, lo_rdata, up_rdata, rdata;

  rmth_pkg::cnt_t  lc_e, uc_e, parent;
  rmth_pkg::cntw_t left_w, right_w;
  rmth_pkg::scnt_t sc_e;
  rmth_pkg::midx_t mc_e;
  logic            go_lower, lb, rb;

  function automatic logic ranks_first(input logic upper, input rmth_pkg::data_t a,
                                       input rmth_pkg::data_t b);
    ranks_first = upper ? (a < b) : (a > b);
  endfunction

  rmth_ram #(.WIDTH(rmth_pkg::DATA_W), .DEPTH(rmth_pkg::HEAP_DEPTH)) u_lower_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we & ~sel_q),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (lo_rdata)
  );

  rmth_ram #(.WIDTH(rmth_pkg::DATA_W), .DEPTH(rmth_pkg::HEAP_DEPTH)) u_upper_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we & sel_q),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (up_rdata)
  );

  assign rdata   = sel_q ? up_rdata : lo_rdata;
  assign parent  = (idx_q - rmth_pkg::cnt_t'(1)) >> 1;
  assign left_w  = {idx_q, 1'b1};
  assign right_w = left_w + rmth_pkg::cntw_t'(1);
  assign lc_e    = first_i ? '0 : lcnt_q;
  assign uc_e    = first_i ? '0 : ucnt_q;
  assign sc_e    = first_i ? '0 : scnt_q;
  assign mc_e    = first_i ? '0 : mcnt_q;
  assign go_lower = (lc_e == '0) || (sample_i < ltop_q);
  assign lb      = ranks_first(sel_q, rdata, key_q);
  assign rb      = ranks_first(sel_q, rdata, best_val_q);

  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    phase_d     = phase_q;
    key_d       = key_q;
    popped_d    = popped_q;
    best_val_d  = best_val_q;
    best_left_d = best_left_q;
    idx_d       = idx_q;
    n_d         = n_q;
    lcnt_d      = lcnt_q;
    ucnt_d      = ucnt_q;
    scnt_d      = scnt_q;
    mcnt_d      = mcnt_q;
    strobe_d    = 1'b0;
    ovf_d       = ovf_q;
    med_d       = med_q;
    midx_d      = midx_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q[rmth_pkg::ADDR_W-1:0];
    mem_wdata   = key_q;
    mem_raddr   = parent[rmth_pkg::ADDR_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (!first_i && scnt_q >= rmth_pkg::CAP_FULL) begin
            strobe_d = 1'b1;
            ovf_d    = 1'b1;
            med_d    = (lcnt_q != '0) ? ltop_q : '0;
            midx_d   = mcnt_q;
          end else begin
            scnt_d  = sc_e;
            mcnt_d  = mc_e;
            key_d   = sample_i;
            phase_d = 1'b0;
            sel_d   = ~go_lower;
            if (go_lower) begin
              idx_d  = lc_e;
              lcnt_d = lc_e + rmth_pkg::cnt_t'(1);
              ucnt_d = uc_e;
            end else begin
              idx_d  = uc_e;
              ucnt_d = uc_e + rmth_pkg::cnt_t'(1);
              lcnt_d = lc_e;
            end
            state_d = S_UP;
          end
        end
      end
      S_UP: begin
        if (idx_q == '0) begin
          mem_we  = 1'b1;
          state_d = phase_q ? S_FIN : S_AFTER;
        end else begin
          state_d = S_UPC;
        end
      end
      S_UPC: begin
        mem_we = 1'b1;
        if (ranks_first(sel_q, key_q, rdata)) begin
          mem_wdata = rdata;
          idx_d     = parent;
          state_d   = S_UP;
        end else begin
          state_d = phase_q ? S_FIN : S_AFTER;
        end
      end
      S_AFTER: begin
        if (lcnt_q < ucnt_q) begin
          sel_d     = 1'b1;
          popped_d  = utop_q;
          ucnt_d    = ucnt_q - rmth_pkg::cnt_t'(1);
          n_d       = ucnt_q - rmth_pkg::cnt_t'(1);
          mem_raddr = n_d[rmth_pkg::ADDR_W-1:0];
          state_d   = S_DNL;
        end else if (rmth_pkg::cntw_t'(lcnt_q) >
                     rmth_pkg::cntw_t'(ucnt_q) + rmth_pkg::cntw_t'(1)) begin
          sel_d     = 1'b0;
          popped_d  = ltop_q;
          lcnt_d    = lcnt_q - rmth_pkg::cnt_t'(1);
          n_d       = lcnt_q - rmth_pkg::cnt_t'(1);
          mem_raddr = n_d[rmth_pkg::ADDR_W-1:0];
          state_d   = S_DNL;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DNL: begin
        key_d   = rdata;
        idx_d   = '0;
        state_d = S_DN;
      end
      S_DN: begin
        mem_raddr = left_w[rmth_pkg::ADDR_W-1:0];
        if (left_w >= rmth_pkg::cntw_t'(n_q)) begin
          mem_we  = 1'b1;
          state_d = S_PUSH2;
        end else begin
          state_d = S_DNLT;
        end
      end
      S_DNLT: begin
        mem_raddr = right_w[rmth_pkg::ADDR_W-1:0];
        if (right_w < rmth_pkg::cntw_t'(n_q)) begin
          best_val_d  = lb ? rdata : key_q;
          best_left_d = lb;
          state_d     = S_DNR;
        end else if (lb) begin
          mem_we    = 1'b1;
          mem_wdata = rdata;
          idx_d     = left_w[rmth_pkg::CNT_W-1:0];
          state_d   = S_DN;
        end else begin
          mem_we  = 1'b1;
          state_d = S_PUSH2;
        end
      end
      S_DNR: begin
        mem_we = 1'b1;
        if (rb) begin
          mem_wdata = rdata;
          idx_d     = right_w[rmth_pkg::CNT_W-1:0];
          state_d   = S_DN;
        end else if (best_left_q) begin
          mem_wdata = best_val_q;
          idx_d     = left_w[rmth_pkg::CNT_W-1:0];
          state_d   = S_DN;
        end else begin
          state_d = S_PUSH2;
        end
      end
      S_PUSH2: begin
        sel_d   = ~sel_q;
        key_d   = popped_q;
        phase_d = 1'b1;
        if (sel_q) begin
          idx_d  = lcnt_q;
          lcnt_d = lcnt_q + rmth_pkg::cnt_t'(1);
        end else begin
          idx_d  = ucnt_q;
          ucnt_d = ucnt_q + rmth_pkg::cnt_t'(1);
        end
        state_d = S_UP;
      end
      S_FIN: begin
        scnt_d = scnt_q + rmth_pkg::scnt_t'(1);
        if (!scnt_q[0]) begin
          mcnt_d   = mcnt_q + rmth_pkg::midx_t'(1);
          strobe_d = 1'b1;
          ovf_d    = 1'b0;
          med_d    = ltop_q;
          midx_d   = mcnt_q + rmth_pkg::midx_t'(1);
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ltop_d = ltop_q;
    utop_d = utop_q;
    if (mem_we && mem_waddr == '0) begin
      if (sel_q) begin
        utop_d = mem_wdata;
      end else begin
        ltop_d = mem_wdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      lcnt_q   <= '0;
      ucnt_q   <= '0;
      scnt_q   <= '0;
      mcnt_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      lcnt_q   <= lcnt_d;
      ucnt_q   <= ucnt_d;
      scnt_q   <= scnt_d;
      mcnt_q   <= mcnt_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q       <= sel_d;
    phase_q     <= phase_d;
    key_q       <= key_d;
    popped_q    <= popped_d;
    best_val_q  <= best_val_d;
    best_left_q <= best_left_d;
    idx_q       <= idx_d;
    n_q         <= n_d;
    ltop_q      <= ltop_d;
    utop_q      <= utop_d;
    ovf_q       <= ovf_d;
    med_q       <= med_d;
    midx_q      <= midx_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign strobe_o       = strobe_q;
  assign median_o       = med_q;
  assign overflow_o     = ovf_q;
  assign median_index_o = midx_q;

  a_balanced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> (lcnt_q == ucnt_q) || (lcnt_q == ucnt_q + rmth_pkg::cnt_t'(1)))
    else $error("heaps unbalanced while idle");

  a_count_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> scnt_q == rmth_pkg::scnt_t'(lcnt_q) + rmth_pkg::scnt_t'(ucnt_q))
    else $error("sample count disagrees with heap sizes");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !busy)
    else $error("result shown while still busy");

endmodule

>>> rtl/rmth_ram.sv
module rmth_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> verif/running_median_two_heaps_top_test.sv
module running_median_two_heaps_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LOWER = 0;
  localparam int UPPER = 1;

  typedef struct packed {
    rmth_pkg::data_t median;
    logic            overflow;
    rmth_pkg::midx_t index;
  } median_res_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  rmth_pkg::data_t sample_i = '0;
  logic            first_i = 1'b0;
  logic            strobe_o;
  rmth_pkg::data_t median_o;
  logic            overflow_o;
  rmth_pkg::midx_t median_index_o;

  rmth_pkg::data_t heap_mem [2][rmth_pkg::HEAP_DEPTH];
  int          heap_cnt [2];
  int          samples_seen;
  int          medians_seen;
  median_res_t median_q[$];
  int          errors = 0;
  int          n_items = 0;
  int          n_results = 0;
  int          n_overflows = 0;
  bit          quiet = 1'b0;

  running_median_two_heaps_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .sample_i       (sample_i),
    .first_i        (first_i),
    .strobe_o       (strobe_o),
    .median_o       (median_o),
    .overflow_o     (overflow_o),
    .median_index_o (median_index_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit ranks_above(int side, rmth_pkg::data_t a, rmth_pkg::data_t b);
    return (side == LOWER) ? (a > b) : (a < b);
  endfunction

  function automatic void heap_insert(int side, rmth_pkg::data_t v);
    int              i;
    int              p;
    rmth_pkg::data_t t;
    i = heap_cnt[side];
    if (i >= rmth_pkg::HEAP_DEPTH) return;
    heap_mem[side][i] = v;
    heap_cnt[side] = i + 1;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!ranks_above(side, heap_mem[side][i], heap_mem[side][p])) break;
      t = heap_mem[side][i];
      heap_mem[side][i] = heap_mem[side][p];
      heap_mem[side][p] = t;
      i = p;
    end
  endfunction

  function automatic rmth_pkg::data_t heap_extract(int side);
    int              n;
    int              i;
    int              l;
    int              best;
    rmth_pkg::data_t top;
    rmth_pkg::data_t t;
    n = heap_cnt[side];
    i = 0;
    if (n == 0) return '0;
    top = heap_mem[side][0];
    n--;
    heap_mem[side][0] = heap_mem[side][n];
    heap_cnt[side] = n;
    forever begin
      l = 2 * i + 1;
      best = i;
      if (l < n && ranks_above(side, heap_mem[side][l], heap_mem[side][best])) best = l;
      if (l + 1 < n && ranks_above(side, heap_mem[side][l+1], heap_mem[side][best]))
        best = l + 1;
      if (best == i) break;
      t = heap_mem[side][i];
      heap_mem[side][i] = heap_mem[side][best];
      heap_mem[side][best] = t;
      i = best;
    end
    return top;
  endfunction

  function automatic void predict_median(rmth_pkg::data_t v, logic first);
    median_res_t r;
    if (first) begin
      heap_cnt[LOWER] = 0;
      heap_cnt[UPPER] = 0;
      samples_seen = 0;
      medians_seen = 0;
    end
    if (samples_seen >= rmth_pkg::CAPACITY) begin
      r.median   = heap_cnt[LOWER] != 0 ? heap_mem[LOWER][0] : '0;
      r.overflow = 1'b1;
      r.index    = rmth_pkg::midx_t'(medians_seen);
      median_q.push_back(r);
      return;
    end
    if (heap_cnt[LOWER] == 0 || v < heap_mem[LOWER][0]) heap_insert(LOWER, v);
    else heap_insert(UPPER, v);
    if (heap_cnt[LOWER] < heap_cnt[UPPER]) heap_insert(LOWER, heap_extract(UPPER));
    else if (heap_cnt[LOWER] > heap_cnt[UPPER] + 1) heap_insert(UPPER, heap_extract(LOWER));
    samples_seen++;
    if (samples_seen % 2 == 0) return;
    medians_seen++;
    r.median   = heap_mem[LOWER][0];
    r.overflow = 1'b0;
    r.index    = rmth_pkg::midx_t'(medians_seen);
    median_q.push_back(r);
  endfunction

  always @(posedge clk_i) begin
    median_res_t want;
    if (rst_ni && strobe_o) begin
      n_results++;
      if (median_q.size() == 0) begin
        $display("%0t: result with none expected: median %0d overflow %0b index %0d",
                 $time, median_o, overflow_o, median_index_o);
        errors++;
      end else begin
        want = median_q.pop_front();
        if (median_o !== want.median) begin
          $display("%0t: median expected %0d actual %0d", $time, want.median, median_o);
          errors++;
        end
        if (overflow_o !== want.overflow) begin
          $display("%0t: overflow expected %0b actual %0b", $time, want.overflow, overflow_o);
          errors++;
        end
        if (median_index_o !== want.index) begin
          $display("%0t: median_index expected %0d actual %0d", $time, want.index,
                   median_index_o);
          errors++;
        end
      end
    end
  end

  task automatic send_sample(rmth_pkg::data_t v, logic first);
    @(negedge clk_i);
    start    <= 1'b1;
    sample_i <= v;
    first_i  <= first;
    do @(posedge clk_i); while (busy);
    predict_median(v, first);
    n_items++;
    if (first == 1'b0 && samples_seen >= rmth_pkg::CAPACITY && median_q.size() > 0 &&
        median_q[$].overflow) n_overflows++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat ($urandom_range(1, 19) - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (median_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic rmth_pkg::data_t pick_sample();
    case ($urandom_range(0, 5))
      0:       return rmth_pkg::data_t'($urandom_range(0, 15)) - 8;
      1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2:       return rmth_pkg::data_t'($urandom_range(0, 2000)) - 1000;
      default: return rmth_pkg::data_t'($urandom);
    endcase
  endfunction

  task automatic test_extremes();
    send_sample(32'sh7fffffff, 1'b1);
    send_sample(32'sh80000000, 1'b0);
    send_sample(32'sh00000000, 1'b0);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sd1, 1'b0);
    send_sample(32'shaaaaaaaa, 1'b0);
    send_sample(32'sh55555555, 1'b0);
    send_sample(32'sd5, 1'b0);
    send_sample(32'sd5, 1'b0);
    send_sample(32'sd5, 1'b0);
    send_sample(32'sh80000000, 1'b1);
    send_sample(32'sh80000000, 1'b0);
    send_sample(32'sh80000000, 1'b0);
    send_sample(32'sd42, 1'b1);
    send_sample(-32'sd42, 1'b1);
    for (int i = 0; i < 9; i++) send_sample(rmth_pkg::data_t'(i * 3 - 12), 1'b0);
    drain_results();
  endtask

  task automatic test_capacity();
    send_sample(pick_sample(), 1'b1);
    for (int i = 1; i < rmth_pkg::CAPACITY; i++) send_sample(pick_sample(), 1'b0);
    send_sample(pick_sample(), 1'b0);
    send_sample(32'sh7fffffff, 1'b0);
    drain_results();
    send_sample(32'sd7, 1'b1);
    drain_results();
  endtask

  task automatic test_sequences(int count, bit allow_idle);
    int left;
    left = count;
    while (left > 0) begin
      send_sample(pick_sample(), 1'b1);
      left--;
      for (int i = $urandom_range(0, 60); i > 0 && left > 0; i--) begin
        send_sample(pick_sample(), $urandom_range(0, 40) == 0);
        left--;
      end
      if (allow_idle && $urandom_range(0, 7) == 0) quiet = ~quiet;
      if (allow_idle && $urandom_range(0, 9) == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_extremes();
    test_capacity();
    test_sequences(40, 1'b1);
    quiet = 1'b1;
    test_sequences(30, 1'b0);
    repeat (100) @(posedge clk_i);
    $display("Sent %0d samples, checked %0d medians including %0d capacity overflows.",
             n_items, n_results, n_overflows);
    $display("Covered field extremes, restarts, ties and a store filled to capacity.");
    if (errors == 0 && median_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Timed out with %0d results outstanding", median_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/rmth_pkg.sv
rtl/rmth_ram.sv
rtl/running_median_two_heaps_top.sv
verif/running_median_two_heaps_top_test.sv
